FILE: hw/rtl/lfdc_pkg.sv
package lfdc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SAMPLE_W    = 10;
    localparam int DUTY_W      = 8;
    localparam int RUN_LEN_W   = 15;
    localparam int MS_W        = 32;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 24;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_SPEED     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_SPEED   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_SENSORS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFETY_LIMIT   = 3'd5;

    localparam logic [DUTY_W-1:0]   RST_BASE_SPEED     = 8'd110;
    localparam logic [DUTY_W-1:0]   RST_TURN_SPEED     = 8'd90;
    localparam logic [DUTY_W-1:0]   RST_SEARCH_SPEED   = 8'd160;
    localparam logic [SAMPLE_W-1:0] RST_LINE_THRESHOLD = 10'd500;
    localparam logic [MS_W-1:0]     RST_SAFETY_LIMIT   = 32'd100000;

    // Input item kinds on tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_BYTE   = 2'd2;

    // Command bytes
    localparam logic [7:0] CH_START_20 = 8'h31;
    localparam logic [7:0] CH_START_25 = 8'h32;
    localparam logic [7:0] CH_START_15 = 8'h33;
    localparam logic [7:0] CH_FWD      = 8'h46;
    localparam logic [7:0] CH_BACK     = 8'h42;
    localparam logic [7:0] CH_LEFT     = 8'h4C;
    localparam logic [7:0] CH_RIGHT    = 8'h52;
    localparam logic [7:0] CH_STOP     = 8'h53;

    localparam logic [RUN_LEN_W-1:0] RUN_LEN_20 = 15'd20000;
    localparam logic [RUN_LEN_W-1:0] RUN_LEN_25 = 15'd25000;
    localparam logic [RUN_LEN_W-1:0] RUN_LEN_15 = 15'd15000;

    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_FOLLOW = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;

    typedef enum logic [2:0] {
        K_NOP,
        K_TICK,
        K_SAMPLE,
        K_START,
        K_DRIVE
    } item_kind_t;

    typedef enum logic [2:0] {
        DRV_FWD,
        DRV_BACK,
        DRV_LEFT,
        DRV_RIGHT,
        DRV_STOP
    } drive_cmd_t;

    // Classified item as it waits in the queue
    typedef struct packed {
        item_kind_t             kind;
        logic [RUN_LEN_W-1:0]   run_len;
        drive_cmd_t             drv;
        logic                   left_on;
        logic                   right_on;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [1:0]        dir;
    } motor_t;

    typedef struct packed {
        logic [DUTY_W-1:0] base_speed;
        logic [DUTY_W-1:0] turn_speed;
        logic [DUTY_W-1:0] search_speed;
        logic [MS_W-1:0]   safety_limit;
    } drive_cfg_t;

    // A motor given zero duty is off regardless of the requested direction.
    function automatic motor_t motor_set(input logic [DUTY_W-1:0] duty, input logic fwd);
        motor_t m;
        m.duty = duty;
        if (duty == '0)
        begin
            m.dir = DIR_OFF;
        end
        else
        begin
            m.dir = fwd ? DIR_FWD : DIR_REV;
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/lfdc_front.sv
module lfdc_front (
    input  logic [1:0]                       opcode,
    input  logic [lfdc_pkg::SAMPLE_W-1:0]    left_sample,
    input  logic [lfdc_pkg::SAMPLE_W-1:0]    right_sample,
    input  logic [7:0]                       cmd_byte,
    input  logic [lfdc_pkg::SAMPLE_W-1:0]    line_threshold,
    input  logic                             invert_sensors,
    output lfdc_pkg::item_t                  item
);
    import lfdc_pkg::*;

    logic left_on;
    logic right_on;

    always_comb
    begin
        if (invert_sensors)
        begin
            left_on  = left_sample > line_threshold;
            right_on = right_sample > line_threshold;
        end
        else
        begin
            left_on  = left_sample < line_threshold;
            right_on = right_sample < line_threshold;
        end
    end

    always_comb
    begin
        item.kind     = K_NOP;
        item.run_len  = RUN_LEN_20;
        item.drv      = DRV_STOP;
        item.left_on  = left_on;
        item.right_on = right_on;
        unique case (opcode)
            OP_TICK:   item.kind = K_TICK;
            OP_SAMPLE: item.kind = K_SAMPLE;
            OP_BYTE:
            begin
                unique case (cmd_byte)
                    CH_START_20: begin item.kind = K_START; item.run_len = RUN_LEN_20; end
                    CH_START_25: begin item.kind = K_START; item.run_len = RUN_LEN_25; end
                    CH_START_15: begin item.kind = K_START; item.run_len = RUN_LEN_15; end
                    CH_FWD:      begin item.kind = K_DRIVE; item.drv = DRV_FWD;   end
                    CH_BACK:     begin item.kind = K_DRIVE; item.drv = DRV_BACK;  end
                    CH_LEFT:     begin item.kind = K_DRIVE; item.drv = DRV_LEFT;  end
                    CH_RIGHT:    begin item.kind = K_DRIVE; item.drv = DRV_RIGHT; end
                    CH_STOP:     begin item.kind = K_DRIVE; item.drv = DRV_STOP;  end
                    default:     item.kind = K_NOP;
                endcase
            end
            default:   item.kind = K_NOP;
        endcase
    end

endmodule

FILE: hw/rtl/lfdc_queue.sv
module lfdc_queue #(
    parameter int DEPTH = lfdc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lfdc_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output lfdc_pkg::item_t  head_item
);
    import lfdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/lfdc_back.sv
module lfdc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lfdc_pkg::drive_cfg_t                cfg,
    input  logic                                item_valid,
    input  lfdc_pkg::item_t                     item,
    output logic                                item_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lfdc_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lfdc_pkg::*;

    motor_t                left_reg, left_next;
    motor_t                right_reg, right_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  halt_reg, halt_next;
    logic                  last_left_reg, last_left_next;
    logic [MS_W-1:0]       elapsed_reg, elapsed_next;
    logic [RUN_LEN_W-1:0]  run_len_reg, run_len_next;
    logic [MS_W-1:0]       since_reg, since_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  ack;
    logic [DUTY_W-1:0]     search_half;

    assign item_pop    = item_valid && (!out_valid_reg || m_tready);
    assign search_half = {1'b0, cfg.search_speed[DUTY_W-1:1]};
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_comb
    begin
        left_next      = left_reg;
        right_next     = right_reg;
        mode_next      = mode_reg;
        halt_next      = halt_reg;
        last_left_next = last_left_reg;
        elapsed_next   = elapsed_reg;
        run_len_next   = run_len_reg;
        since_next     = since_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ack            = 1'b0;

        if (item_pop)
        begin
            unique case (item.kind)
                K_TICK:
                begin
                    if (since_reg != '1)
                    begin
                        since_next = since_reg + 1'b1;
                    end
                    if (mode_reg == MODE_RUN && elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                K_START:
                begin
                    ack = 1'b1;
                    if (mode_reg != MODE_RUN)
                    begin
                        mode_next    = MODE_RUN;
                        elapsed_next = '0;
                        run_len_next = item.run_len;
                    end
                end
                K_DRIVE:
                begin
                    ack       = 1'b1;
                    mode_next = MODE_FOLLOW;
                    unique case (item.drv)
                        DRV_FWD:
                        begin
                            left_next  = motor_set(cfg.base_speed, 1'b1);
                            right_next = motor_set(cfg.base_speed, 1'b1);
                        end
                        DRV_BACK:
                        begin
                            left_next  = motor_set(cfg.base_speed, 1'b0);
                            right_next = motor_set(cfg.base_speed, 1'b0);
                        end
                        DRV_LEFT:
                        begin
                            left_next  = motor_set(cfg.turn_speed, 1'b0);
                            right_next = motor_set(cfg.turn_speed, 1'b1);
                        end
                        DRV_RIGHT:
                        begin
                            left_next  = motor_set(cfg.turn_speed, 1'b1);
                            right_next = motor_set(cfg.turn_speed, 1'b0);
                        end
                        default:
                        begin
                            left_next  = motor_set('0, 1'b1);
                            right_next = motor_set('0, 1'b1);
                        end
                    endcase
                end
                default: ;
            endcase

            // The safety limit is checked after every item and trips only once.
            if (!halt_reg && since_next >= cfg.safety_limit)
            begin
                halt_next  = 1'b1;
                left_next  = motor_set('0, 1'b1);
                right_next = motor_set('0, 1'b1);
            end

            // A sample item changes neither the mode nor the run clock before this point.
            if (item.kind == K_SAMPLE && !halt_next && mode_reg == MODE_RUN)
            begin
                priority if (item.left_on && item.right_on)
                begin
                    left_next  = motor_set(cfg.base_speed, 1'b1);
                    right_next = motor_set(cfg.base_speed, 1'b1);
                end
                else if (item.left_on)
                begin
                    left_next      = motor_set(cfg.turn_speed, 1'b0);
                    right_next     = motor_set(cfg.turn_speed, 1'b1);
                    last_left_next = 1'b1;
                end
                else if (item.right_on)
                begin
                    left_next      = motor_set(cfg.turn_speed, 1'b1);
                    right_next     = motor_set(cfg.turn_speed, 1'b0);
                    last_left_next = 1'b0;
                end
                else if (last_left_reg)
                begin
                    left_next  = motor_set(search_half, 1'b1);
                    right_next = motor_set(cfg.search_speed, 1'b1);
                end
                else
                begin
                    left_next  = motor_set(cfg.search_speed, 1'b1);
                    right_next = motor_set(search_half, 1'b1);
                end
                if (elapsed_reg >= {{(MS_W-RUN_LEN_W){1'b0}}, run_len_reg})
                begin
                    left_next  = motor_set('0, 1'b1);
                    right_next = motor_set('0, 1'b1);
                    mode_next  = MODE_IDLE;
                end
            end

            out_valid_next = 1'b1;
            out_data_next  = {ack, halt_next, mode_next, right_next.dir, right_next.duty,
                              left_next.dir, left_next.duty};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            mode_reg      <= MODE_IDLE;
            halt_reg      <= 1'b0;
            last_left_reg <= 1'b0;
            elapsed_reg   <= '0;
            run_len_reg   <= '0;
            since_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            mode_reg      <= mode_next;
            halt_reg      <= halt_next;
            last_left_reg <= last_left_next;
            elapsed_reg   <= elapsed_next;
            run_len_reg   <= run_len_next;
            since_reg     <= since_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

FILE: hw/rtl/line_follower_drive_controller.sv
// Two-motor line follower drive controller. Every input item (a millisecond tick, a sensor
// sample pair or a command byte, selected by s_tuser) produces exactly one result item that
// shows the drive, mode and halt state after that item, plus an acknowledge for recognized
// command bytes. Items are classified on entry, wait in a small queue and are executed by the
// drive engine one per clock cycle while the output is not stalled, so the block then sustains
// one item per cycle; a result passes through the queue and the output register before it is
// presented. The output register lets the next item be executed while the current result is
// being taken. Configuration registers are written through cfg_we, cfg_index and cfg_data
// while the block is idle; the user must ensure this, as the block does not enforce it. They
// take effect for the next accepted item.
module line_follower_drive_controller #(
    parameter int QUEUE_DEPTH = lfdc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lfdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lfdc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: left_sample[9:0], right_sample[19:10], cmd_byte[27:20], zero fill[31:28]
    input  logic [lfdc_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: left_duty[7:0], left_dir[9:8], right_duty[17:10], right_dir[19:18],
    //          mode[21:20], halted[22], ack[23]
    output logic [lfdc_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import lfdc_pkg::*;

    logic [DUTY_W-1:0]   base_speed_reg;
    logic [DUTY_W-1:0]   turn_speed_reg;
    logic [DUTY_W-1:0]   search_speed_reg;
    logic [SAMPLE_W-1:0] line_threshold_reg;
    logic                invert_sensors_reg;
    logic [MS_W-1:0]     safety_limit_reg;

    item_t      in_item;
    item_t      head_item;
    logic       queue_full;
    logic       queue_not_empty;
    logic       queue_pop;
    logic       push;
    drive_cfg_t drive_cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg     <= RST_BASE_SPEED;
            turn_speed_reg     <= RST_TURN_SPEED;
            search_speed_reg   <= RST_SEARCH_SPEED;
            line_threshold_reg <= RST_LINE_THRESHOLD;
            invert_sensors_reg <= 1'b0;
            safety_limit_reg   <= RST_SAFETY_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_SPEED:     base_speed_reg     <= cfg_data[DUTY_W-1:0];
                REG_TURN_SPEED:     turn_speed_reg     <= cfg_data[DUTY_W-1:0];
                REG_SEARCH_SPEED:   search_speed_reg   <= cfg_data[DUTY_W-1:0];
                REG_LINE_THRESHOLD: line_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                REG_INVERT_SENSORS: invert_sensors_reg <= cfg_data[0];
                REG_SAFETY_LIMIT:   safety_limit_reg   <= cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign drive_cfg.base_speed   = base_speed_reg;
    assign drive_cfg.turn_speed   = turn_speed_reg;
    assign drive_cfg.search_speed = search_speed_reg;
    assign drive_cfg.safety_limit = safety_limit_reg;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    lfdc_front u_front (
        .opcode         (s_tuser),
        .left_sample    (s_tdata[9:0]),
        .right_sample   (s_tdata[19:10]),
        .cmd_byte       (s_tdata[27:20]),
        .line_threshold (line_threshold_reg),
        .invert_sensors (invert_sensors_reg),
        .item           (in_item)
    );

    lfdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    lfdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (drive_cfg),
        .item_valid (queue_not_empty),
        .item       (head_item),
        .item_pop   (queue_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
